>>> hw/rtl/bdll_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// bdll_pkg
// Opcodes, status codes and the response word shared by the list engine.
// ============================================================================
package bdll_pkg;

    localparam int OPCODE_W   = 4;
    localparam int VALUE_W    = 32;
    localparam int POSITION_W = 6;
    localparam int STATUS_W   = 2;
    localparam int READ_LIMIT = 32;

    localparam logic [OPCODE_W-1:0] OP_APPEND     = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_READ_ALL   = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_INSERT     = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 4'd5;
    localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_DELETE     = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_LENGTH     = 4'd8;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic [STATUS_W-1:0]       status;
        logic                      last;
    } rsp_word_t;

endpackage

>>> hw/rtl/bdll_cmd_if.sv
`timescale 1ns / 1ps
// ============================================================================
// bdll_cmd_if
// Command channel: valid/ready with opcode, value and position.
// ============================================================================
interface bdll_cmd_if;
    import bdll_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [OPCODE_W-1:0]          opcode;
    logic signed [VALUE_W-1:0]    item_value;
    logic [POSITION_W-1:0]        position;

    modport source (output valid, output opcode, output item_value, output position,
                    input ready);
    modport sink   (input valid, input opcode, input item_value, input position,
                    output ready);
endinterface

>>> hw/rtl/bdll_rsp_if.sv
`timescale 1ns / 1ps
// ============================================================================
// bdll_rsp_if
// Response channel: valid/ready with result value, status and last flag.
// ============================================================================
interface bdll_rsp_if;
    import bdll_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [VALUE_W-1:0]    result_value;
    logic [STATUS_W-1:0]          status;
    logic                         last;

    modport source (output valid, output result_value, output status, output last,
                    input ready);
    modport sink   (input valid, input result_value, input status, input last,
                    output ready);
endinterface

>>> hw/rtl/bdll_store.sv
`timescale 1ns / 1ps
// ============================================================================
// bdll_store
// Slot storage: value, forward link and backward link memories. One shared
// read address with registered data, one write port per memory.
// ============================================================================
module bdll_store
    import bdll_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int IW    = 5
)
(
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [IW-1:0]             rd_addr,
    output logic signed [VALUE_W-1:0] rd_value,
    output logic [IW-1:0]             rd_next,
    output logic [IW-1:0]             rd_prev,
    input  logic                      val_we,
    input  logic [IW-1:0]             val_addr,
    input  logic signed [VALUE_W-1:0] val_data,
    input  logic                      nxt_we,
    input  logic [IW-1:0]             nxt_addr,
    input  logic [IW-1:0]             nxt_data,
    input  logic                      prv_we,
    input  logic [IW-1:0]             prv_addr,
    input  logic [IW-1:0]             prv_data
);

    logic signed [VALUE_W-1:0] val_mem [DEPTH];
    logic [IW-1:0]             nxt_mem [DEPTH];
    logic [IW-1:0]             prv_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_addr] <= val_data;
        end
        if (nxt_we)
        begin
            nxt_mem[nxt_addr] <= nxt_data;
        end
        if (prv_we)
        begin
            prv_mem[prv_addr] <= prv_data;
        end
        if (rd_en)
        begin
            rd_value <= val_mem[rd_addr];
            rd_next  <= nxt_mem[rd_addr];
            rd_prev  <= prv_mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/bdll_out_reg.sv
`timescale 1ns / 1ps
// ============================================================================
// bdll_out_reg
// Response output register: holds one word until the receiver takes it.
// ============================================================================
module bdll_out_reg
    import bdll_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rsp_word_t     push_word,
    output logic          can_push,
    bdll_rsp_if.source    rsp
);

    logic      valid_reg;
    logic      valid_next;
    rsp_word_t word_reg;

    assign can_push = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            word_reg <= push_word;
        end
    end

    assign rsp.valid        = valid_reg;
    assign rsp.result_value = word_reg.result_value;
    assign rsp.status       = word_reg.status;
    assign rsp.last         = word_reg.last;

endmodule

>>> hw/rtl/bounded_doubly_linked_list_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// bounded_doubly_linked_list_unit
// Ordered list of up to CAPACITY signed 32-bit values in linked memory slots.
// ============================================================================
// Usage:
//   cmd carries one operation per word (opcode, item_value, position). rsp
//   returns one word per operation, or one word per element (up to READ_LIMIT) for read all,
//   with last set on the final word of each operation.
//   Operations run one at a time; cmd.ready is high only while the sequencer
//   is idle and the output register can take a word.
//   Insert places the new value after position p; delete removes the
//   element at position p. The walk follows one forward link per cycle
//   through the link memory's single read port.
//   Reset empties the list at once: the slot bitmap, head, tail and count
//   are registers; slot memories need no clearing.
//   When rsp stalls, the output register holds its word and the sequencer
//   waits, holding the memory read data of the element in flight.
// ============================================================================
module bounded_doubly_linked_list_unit
    import bdll_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    bdll_cmd_if.sink   cmd,
    bdll_rsp_if.source rsp
);

    localparam int IW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_LINK = 3'd2;
    localparam logic [2:0] S_WR1  = 3'd3;
    localparam logic [2:0] S_WR2  = 3'd4;
    localparam logic [2:0] S_READ = 3'd5;

    // control state
    logic [2:0]            state_reg, state_next;
    logic [CAPACITY-1:0]   used_reg, used_next;
    logic [IW-1:0]         head_reg, head_next;
    logic [IW-1:0]         tail_reg, tail_next;
    logic [CW-1:0]         count_reg, count_next;
    // per-operation working registers
    logic [OPCODE_W-1:0]   op_reg, op_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic [POSITION_W-1:0] hops_reg, hops_next;
    logic [IW-1:0]         cur_reg, cur_next;
    logic [IW-1:0]         nx_reg, nx_next;
    logic [IW-1:0]         pv_reg, pv_next;
    logic [IW-1:0]         new_reg, new_next;
    logic [CW-1:0]         rem_reg, rem_next;

    // memory ports
    logic                      rd_en;
    logic [IW-1:0]             rd_addr;
    logic signed [VALUE_W-1:0] rd_value;
    logic [IW-1:0]             rd_next;
    logic [IW-1:0]             rd_prev;
    logic                      val_we, nxt_we, prv_we;
    logic [IW-1:0]             val_addr, nxt_addr, prv_addr;
    logic [IW-1:0]             nxt_data, prv_data;

    // output register
    logic      push;
    rsp_word_t push_word;
    logic      can_push;

    logic                  accept;
    logic                  is_empty;
    logic                  is_full;
    logic                  bad_pos;
    logic [POSITION_W-1:0] pos_eff;
    logic [IW-1:0]         free_slot;
    logic [CW-1:0]         read_count;

    assign cmd.ready = (state_reg == S_IDLE) && can_push;
    assign accept    = cmd.valid && cmd.ready;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CW'(CAPACITY));
    assign pos_eff   = (cmd.position == '0) ? POSITION_W'(1) : cmd.position;
    assign bad_pos   = 8'(pos_eff) > 8'(count_reg);
    assign read_count = (8'(count_reg) > 8'(READ_LIMIT)) ? CW'(READ_LIMIT) : count_reg;

    // lowest free slot
    always_comb
    begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot = IW'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        op_next    = op_reg;
        val_next   = val_reg;
        hops_next  = hops_reg;
        cur_next   = cur_reg;
        nx_next    = nx_reg;
        pv_next    = pv_reg;
        new_next   = new_reg;
        rem_next   = rem_reg;

        rd_en    = 1'b0;
        rd_addr  = cur_reg;
        val_we   = 1'b0;
        nxt_we   = 1'b0;
        prv_we   = 1'b0;
        val_addr = new_reg;
        nxt_addr = new_reg;
        prv_addr = new_reg;
        nxt_data = '0;
        prv_data = '0;

        push      = 1'b0;
        push_word = '{result_value: '0, status: ST_OK, last: 1'b1};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = cmd.opcode;
                    val_next  = cmd.item_value;
                    new_next  = free_slot;
                    hops_next = pos_eff - POSITION_W'(1);
                    case (cmd.opcode)
                        OP_APPEND:
                        begin
                            if (is_full)
                            begin
                                push = 1'b1;
                                push_word.status = ST_FULL;
                            end
                            else
                            begin
                                state_next = S_WR1;
                            end
                        end
                        OP_READ_ALL:
                        begin
                            if (is_empty)
                            begin
                                push = 1'b1;
                                push_word.status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                cur_next   = head_reg;
                                rem_next   = read_count;
                                state_next = S_READ;
                            end
                        end
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            if (is_empty)
                            begin
                                push = 1'b1;
                                push_word.status = ST_EMPTY;
                            end
                            else if (is_full)
                            begin
                                push = 1'b1;
                                push_word.status = ST_FULL;
                            end
                            else
                            begin
                                state_next = S_WR1;
                            end
                        end
                        OP_INSERT, OP_DELETE:
                        begin
                            if (is_empty)
                            begin
                                push = 1'b1;
                                push_word.status = ST_EMPTY;
                            end
                            else if (bad_pos)
                            begin
                                push = 1'b1;
                                push_word.status = ST_BADPOS;
                            end
                            else if (is_full && cmd.opcode == OP_INSERT)
                            begin
                                push = 1'b1;
                                push_word.status = ST_FULL;
                            end
                            else
                            begin
                                // start the walk at the head
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                cur_next   = head_reg;
                                state_next = (pos_eff == POSITION_W'(1)) ? S_LINK : S_WALK;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                push = 1'b1;
                                push_word.status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = (cmd.opcode == OP_POP_FRONT) ? head_reg : tail_reg;
                                cur_next   = rd_addr;
                                state_next = S_LINK;
                            end
                        end
                        OP_LENGTH:
                        begin
                            push = 1'b1;
                            push_word.result_value = signed'(VALUE_W'(count_reg));
                        end
                        default:
                        begin
                            push = 1'b1;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                // advance one forward link per cycle
                cur_next  = rd_next;
                rd_en     = 1'b1;
                rd_addr   = rd_next;
                hops_next = hops_reg - POSITION_W'(1);
                if (hops_reg == POSITION_W'(1))
                begin
                    state_next = S_LINK;
                end
            end

            S_LINK:
            begin
                nx_next    = rd_next;
                pv_next    = rd_prev;
                state_next = (op_reg == OP_INSERT) ? S_WR1 : S_WR2;
            end

            S_WR1:
            begin
                // fill the new slot
                val_we   = 1'b1;
                nxt_we   = 1'b1;
                prv_we   = 1'b1;
                val_addr = new_reg;
                nxt_addr = new_reg;
                prv_addr = new_reg;
                case (op_reg)
                    OP_PUSH_FRONT:
                    begin
                        nxt_data = head_reg;
                        prv_data = '0;
                    end
                    OP_INSERT:
                    begin
                        nxt_data = nx_reg;
                        prv_data = cur_reg;
                    end
                    default:
                    begin
                        nxt_data = '0;
                        prv_data = tail_reg;
                    end
                endcase
                used_next[new_reg] = 1'b1;
                count_next = count_reg + CW'(1);
                state_next = S_WR2;
            end

            S_WR2:
            begin
                if (can_push)
                begin
                    case (op_reg)
                        OP_APPEND, OP_PUSH_BACK:
                        begin
                            if (count_reg == CW'(1))
                            begin
                                head_next = new_reg;
                            end
                            else
                            begin
                                nxt_we   = 1'b1;
                                nxt_addr = tail_reg;
                                nxt_data = new_reg;
                            end
                            tail_next = new_reg;
                        end
                        OP_PUSH_FRONT:
                        begin
                            prv_we    = 1'b1;
                            prv_addr  = head_reg;
                            prv_data  = new_reg;
                            head_next = new_reg;
                        end
                        OP_INSERT:
                        begin
                            nxt_we   = 1'b1;
                            nxt_addr = cur_reg;
                            nxt_data = new_reg;
                            if (cur_reg == tail_reg)
                            begin
                                tail_next = new_reg;
                            end
                            else
                            begin
                                prv_we   = 1'b1;
                                prv_addr = nx_reg;
                                prv_data = new_reg;
                            end
                        end
                        default:
                        begin
                            // unlink cur_reg
                            if (count_reg == CW'(1))
                            begin
                                head_next = '0;
                                tail_next = '0;
                            end
                            else
                            begin
                                if (cur_reg == head_reg)
                                begin
                                    head_next = nx_reg;
                                end
                                else
                                begin
                                    nxt_we   = 1'b1;
                                    nxt_addr = pv_reg;
                                    nxt_data = nx_reg;
                                end
                                if (cur_reg == tail_reg)
                                begin
                                    tail_next = pv_reg;
                                end
                                else
                                begin
                                    prv_we   = 1'b1;
                                    prv_addr = nx_reg;
                                    prv_data = pv_reg;
                                end
                            end
                            used_next[cur_reg] = 1'b0;
                            count_next = count_reg - CW'(1);
                        end
                    endcase
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_READ:
            begin
                // emit one element per cycle; hold read data while stalled
                if (can_push)
                begin
                    push = 1'b1;
                    push_word.result_value = rd_value;
                    push_word.last = (rem_reg == CW'(1));
                    if (rem_reg == CW'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = rd_next;
                        rem_next = rem_reg - CW'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        val_reg  <= val_next;
        hops_reg <= hops_next;
        cur_reg  <= cur_next;
        nx_reg   <= nx_next;
        pv_reg   <= pv_next;
        new_reg  <= new_next;
        rem_reg  <= rem_next;
    end

    bdll_store #(
        .DEPTH (CAPACITY),
        .IW    (IW)
    ) u_store (
        .clk      (clk),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_value (rd_value),
        .rd_next  (rd_next),
        .rd_prev  (rd_prev),
        .val_we   (val_we),
        .val_addr (val_addr),
        .val_data (val_reg),
        .nxt_we   (nxt_we),
        .nxt_addr (nxt_addr),
        .nxt_data (nxt_data),
        .prv_we   (prv_we),
        .prv_addr (prv_addr),
        .prv_data (prv_data)
    );

    bdll_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .can_push  (can_push),
        .rsp       (rsp)
    );

endmodule

>>> sim/tb_bounded_doubly_linked_list_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_bounded_doubly_linked_list_unit
// Self-checking bench for the list engine. A list predictor mirrors every
// accepted operation word and queues the expected response words. A monitor
// compares each accepted response word against the oldest one in the queue.
// ============================================================================
module tb_bounded_doubly_linked_list_unit;
    import bdll_pkg::*;

    localparam int CAP = 32;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    bdll_cmd_if cmd ();
    bdll_rsp_if rsp ();

    bounded_doubly_linked_list_unit #(.CAPACITY(CAP)) DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .rsp   (rsp.source)
    );

    // Predictor state: the list is kept as a plain ordered array.
    logic signed [VALUE_W-1:0] list_vals[$];
    rsp_word_t                 expected_words[$];

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;
    int  hold_cycles;
    int  error_count;
    int  cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Advance the cycle counter; end the run if it blows the limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic rsp_word_t mk(logic signed [VALUE_W-1:0] v,
                                     logic [STATUS_W-1:0] s, logic l);
        rsp_word_t w;
        w.result_value = v;
        w.status       = s;
        w.last         = l;
        return w;
    endfunction

    // Apply one operation to the list mirror and queue its response words.
    function automatic void predict_list_op(logic [OPCODE_W-1:0] op,
                                            logic signed [VALUE_W-1:0] v,
                                            logic [POSITION_W-1:0] pos);
        int n;
        int p;
        n = list_vals.size();
        p = (pos == 0) ? 1 : int'(pos);
        case (op)
            OP_APPEND:
                if (n >= CAP) expected_words.push_back(mk(0, ST_FULL, 1'b1));
                else
                begin
                    list_vals.push_back(v);
                    expected_words.push_back(mk(0, ST_OK, 1'b1));
                end
            OP_READ_ALL:
                if (n == 0) expected_words.push_back(mk(0, ST_EMPTY, 1'b1));
                else
                    for (int i = 0; i < n && i < READ_LIMIT; i++)
                        expected_words.push_back(mk(list_vals[i], ST_OK,
                            (i + 1 == n || i + 1 == READ_LIMIT)));
            OP_PUSH_FRONT, OP_PUSH_BACK:
                if (n == 0) expected_words.push_back(mk(0, ST_EMPTY, 1'b1));
                else if (n >= CAP) expected_words.push_back(mk(0, ST_FULL, 1'b1));
                else
                begin
                    if (op == OP_PUSH_FRONT) list_vals.push_front(v);
                    else list_vals.push_back(v);
                    expected_words.push_back(mk(0, ST_OK, 1'b1));
                end
            OP_INSERT:
                if (n == 0) expected_words.push_back(mk(0, ST_EMPTY, 1'b1));
                else if (p > n) expected_words.push_back(mk(0, ST_BADPOS, 1'b1));
                else if (n >= CAP) expected_words.push_back(mk(0, ST_FULL, 1'b1));
                else
                begin
                    list_vals.insert(p, v);
                    expected_words.push_back(mk(0, ST_OK, 1'b1));
                end
            OP_POP_FRONT, OP_POP_BACK:
                if (n == 0) expected_words.push_back(mk(0, ST_EMPTY, 1'b1));
                else
                begin
                    if (op == OP_POP_FRONT) void'(list_vals.pop_front());
                    else void'(list_vals.pop_back());
                    expected_words.push_back(mk(0, ST_OK, 1'b1));
                end
            OP_DELETE:
                if (n == 0) expected_words.push_back(mk(0, ST_EMPTY, 1'b1));
                else if (p > n) expected_words.push_back(mk(0, ST_BADPOS, 1'b1));
                else
                begin
                    list_vals.delete(p - 1);
                    expected_words.push_back(mk(0, ST_OK, 1'b1));
                end
            OP_LENGTH:
                expected_words.push_back(mk(n, ST_OK, 1'b1));
            default:
                expected_words.push_back(mk(0, ST_OK, 1'b1));
        endcase
    endfunction

    // Receiver: drop ready at random, or hold off entirely during a pressure burst.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // Count down the long hold-off in its own process.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_off    <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            hold_off <= 1'b0;
    end

    // Check each accepted response word against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected response word value=%0d status=%0d last=%0d",
                       rsp.result_value, rsp.status, rsp.last);
                error_count++;
            end
            else
            begin
                rsp_word_t w;
                w = expected_words.pop_front();
                if (rsp.result_value !== w.result_value)
                begin
                    $error("result_value expected %0d actual %0d",
                           w.result_value, rsp.result_value);
                    error_count++;
                end
                if (rsp.status !== w.status)
                begin
                    $error("status expected %0d actual %0d", w.status, rsp.status);
                    error_count++;
                end
                if (rsp.last !== w.last)
                begin
                    $error("last expected %0d actual %0d", w.last, rsp.last);
                    error_count++;
                end
            end
        end
    end

    // Offer one operation word, with a random gap ahead of it; hold until accepted.
    // Valid stays high after acceptance; the next gap or drain drops it.
    task automatic send_op(logic [OPCODE_W-1:0] op, logic signed [VALUE_W-1:0] v,
                           logic [POSITION_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid      <= 1'b1;
        cmd.opcode     <= op;
        cmd.item_value <= v;
        cmd.position   <= pos;
        do
            @(posedge clk);
        while (!cmd.ready);
        predict_list_op(op, v, pos);
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (CAP + 10) @(posedge clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(3))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            default: return $urandom;
        endcase
    endfunction

    // Empty-list answers, the first append, and the extremes of every field.
    task automatic test_directed();
        send_op(OP_READ_ALL, 0, 0);
        send_op(OP_LENGTH, 0, 0);
        send_op(OP_PUSH_FRONT, 5, 0);
        send_op(OP_PUSH_BACK, 5, 0);
        send_op(OP_INSERT, 5, 1);
        send_op(OP_POP_FRONT, 0, 0);
        send_op(OP_POP_BACK, 0, 0);
        send_op(OP_DELETE, 0, 1);
        send_op(OP_APPEND, 32'sh7FFFFFFF, 6'h3F);
        send_op(OP_PUSH_FRONT, 32'sh80000000, 0);
        send_op(OP_PUSH_BACK, -1, 0);
        send_op(OP_INSERT, 32'sh55555555, 0);
        send_op(OP_INSERT, 32'shAAAAAAAA, 4);
        send_op(OP_INSERT, 7, 6);
        send_op(OP_DELETE, 0, 6'h3F);
        send_op(OP_READ_ALL, 0, 0);
        send_op(OP_DELETE, 0, 0);
        send_op(OP_DELETE, 0, 3);
        send_op(4'd9, 1, 1);
        send_op(4'd15, -1, 6'h3F);
        send_op(OP_LENGTH, 0, 0);
        send_op(OP_POP_FRONT, 0, 0);
        send_op(OP_POP_BACK, 0, 0);
        send_op(OP_DELETE, 0, 1);
        send_op(OP_READ_ALL, 0, 0);
    endtask

    // Fill to capacity, hit the full answers, read back, then empty again.
    task automatic test_full_store();
        send_op(OP_APPEND, rand_value(), 0);
        while (list_vals.size() < CAP)
            send_op($urandom_range(1) ? OP_PUSH_FRONT : OP_INSERT, rand_value(),
                    POSITION_W'($urandom_range(list_vals.size())));
        send_op(OP_APPEND, 1, 0);
        send_op(OP_PUSH_FRONT, 1, 0);
        send_op(OP_PUSH_BACK, 1, 0);
        send_op(OP_INSERT, 1, POSITION_W'(CAP));
        send_op(OP_INSERT, 1, POSITION_W'(CAP + 1));
        send_op(OP_READ_ALL, 0, 0);
        send_op(OP_DELETE, 0, POSITION_W'(CAP));
        while (list_vals.size() > 0)
            send_op(OP_DELETE, 0, POSITION_W'($urandom_range(list_vals.size())));
    endtask

    // Mostly list-growing and list-walking ops with random content.
    task automatic test_random_ops(int count);
        logic [OPCODE_W-1:0] op;
        int n;
        for (int i = 0; i < count; i++)
        begin
            n = list_vals.size();
            case ($urandom_range(19))
                0, 1, 2:    op = OP_APPEND;
                3, 4:       op = OP_PUSH_FRONT;
                5, 6:       op = OP_PUSH_BACK;
                7, 8, 9:    op = OP_INSERT;
                10:         op = OP_POP_FRONT;
                11:         op = OP_POP_BACK;
                12, 13, 14: op = OP_DELETE;
                15, 16:     op = OP_READ_ALL;
                17:         op = OP_LENGTH;
                default:    op = OPCODE_W'($urandom_range(15));
            endcase
            send_op(op, rand_value(),
                    ($urandom_range(9) == 0) ? POSITION_W'($urandom_range(63))
                                             : POSITION_W'($urandom_range(n + 1)));
        end
    endtask

    // Stall the receiver for a long stretch while commands keep coming.
    task automatic test_backpressure();
        hold_cycles <= 300;
        for (int i = 0; i < 6; i++)
            send_op(OP_APPEND, rand_value(), 0);
        send_op(OP_READ_ALL, 0, 0);
        send_op(OP_READ_ALL, 0, 0);
        for (int i = 0; i < 6; i++)
            send_op(OP_POP_BACK, 0, 0);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cmd.valid      = 1'b0;
        cmd.opcode     = OP_LENGTH;
        cmd.item_value = '0;
        cmd.position   = '0;
        hold_off       = 1'b0;
        hold_cycles    = 0;
        error_count    = 0;
        cycle_count    = 0;
        send_idle_pct  = 12;
        recv_idle_pct  = 81;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_store();
        test_random_ops(50);

        send_idle_pct = 81;
        recv_idle_pct = 12;
        test_backpressure();
        test_random_ops(50);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_ops(40);
        drain();

        if (error_count == 0 && expected_words.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

>>> files.f
hw/rtl/bdll_pkg.sv
hw/rtl/bdll_cmd_if.sv
hw/rtl/bdll_rsp_if.sv
hw/rtl/bdll_store.sv
hw/rtl/bdll_out_reg.sv
hw/rtl/bounded_doubly_linked_list_unit.sv
sim/tb_bounded_doubly_linked_list_unit.sv
